// File: rtl/core/ils_pkg.sv
// ils_pkg: shared types for the indexed list store
// holds the shift command that the top level broadcasts to the row of cells
// no dependencies

package ils_pkg;

    // shift command broadcast to every cell of the row
    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_INSERT,
        SHIFT_REMOVE
    } shift_op_t;

    // one cycle's command to the cell row
    typedef struct packed {
        shift_op_t op;
        logic      hit_en;
    } cell_ctrl_t;

endpackage

// File: rtl/core/ils_cell.sv
// ils_cell: one storage cell of the list shift row
// holds one data word, shifts from its lower or upper neighbor, taps out on a hit
// depends on ils_pkg

module ils_cell #(
    parameter int INDEX      = 0,
    parameter int IW         = 5,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  ils_pkg::cell_ctrl_t   ctrl,
    input  logic [IW-1:0]         target,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] lower,
    input  logic [DATA_WIDTH-1:0] upper,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);

    localparam logic [IW-1:0] IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // next word from the shift command
    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            ils_pkg::SHIFT_HOLD:
            begin
                data_next = data_reg;
            end
            ils_pkg::SHIFT_INSERT:
            begin
                priority if (IDX > target)
                    data_next = lower;
                else if (IDX == target)
                    data_next = word;
                else
                    data_next = data_reg;
            end
            ils_pkg::SHIFT_REMOVE:
            begin
                if (IDX >= target)
                    data_next = upper;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // word storage, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // neighbor output and gated read tap
    assign data = data_reg;
    assign tap  = (ctrl.hit_en && (IDX == target)) ? data_reg : '0;

endmodule

// File: rtl/core/indexed_list_store.sv
// indexed_list_store: bounded ordered list kept in a row of shifting cells
// top level with command decode, entry count and registered result word
// depends on ils_pkg and ils_cell
//
// Usage: the input channel (in_valid, in_stall) takes one command word per
// accepted cycle: mode, position and value. The output channel (out_valid,
// out_stall) returns exactly one result word per command: read_data,
// entry_count and error, in command order.
// The result is registered in the output register when the command is
// accepted. Throughput: one command per cycle while in_stall is low; every cell decides from its
// own index and the broadcast target in the same cycle, and the read word is
// an OR over the cell taps.
// Reset: rst_n (asynchronous, active low) empties the list and the output
// register. Cell contents stay undefined until written, but a cell is only
// read below the entry count.
// Stall: while a result waits under out_stall, in_stall is raised and the
// result holds; with out_stall low a new command is taken every cycle.
// Refused commands (full list, bad position, empty list) leave the list
// unchanged and return error 1 with read_data zero.

module indexed_list_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [4:0]  position,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [4:0]  entry_count,
    output logic        error
);

    localparam int IW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (IW > 5) ? IW : 5;

    typedef enum logic [2:0] {
        MODE_APPEND,
        MODE_PREPEND,
        MODE_INSERT,
        MODE_REMOVE_AT,
        MODE_REMOVE_FIRST,
        MODE_REMOVE_LAST,
        MODE_READ,
        MODE_CLEAR
    } mode_t;

    logic [IW-1:0]           count_reg;
    logic [IW-1:0]           count_next;
    logic                    out_valid_reg;
    logic [31:0]             read_data_reg;
    logic [4:0]              entry_count_reg;
    logic                    error_reg;

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic [CMPW-1:0]         pos_c;
    logic [CMPW-1:0]         cnt_c;
    logic [IW-1:0]           pos_i;
    ils_pkg::shift_op_t      op;
    logic                    rd_en;
    logic                    err;
    logic [IW-1:0]           target;
    ils_pkg::cell_ctrl_t     ctrl;
    logic [DATA_WIDTH+31:0]  value_wide;
    logic [DATA_WIDTH-1:0]   word;
    logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]   cell_tap  [CAPACITY];
    logic [DATA_WIDTH-1:0]   rd_any;
    logic [DATA_WIDTH+31:0]  rd_wide;
    logic [IW+4:0]           count_wide;

    // handshake
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // operand forms
    assign full       = (count_reg == IW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign pos_c      = CMPW'(position);
    assign cnt_c      = CMPW'(count_reg);
    assign pos_i      = pos_c[IW-1:0];
    assign value_wide = (DATA_WIDTH + 32)'(value);
    assign word       = value_wide[DATA_WIDTH-1:0];

    // command decode
    always_comb
    begin
        op         = ils_pkg::SHIFT_HOLD;
        rd_en      = 1'b0;
        err        = 1'b0;
        target     = '0;
        count_next = count_reg;
        unique case (mode_t'(mode))
            MODE_APPEND:
            begin
                if (full)
                    err = 1'b1;
                else
                begin
                    op         = ils_pkg::SHIFT_INSERT;
                    target     = count_reg;
                    count_next = count_reg + IW'(1);
                end
            end
            MODE_PREPEND:
            begin
                if (full)
                    err = 1'b1;
                else
                begin
                    op         = ils_pkg::SHIFT_INSERT;
                    count_next = count_reg + IW'(1);
                end
            end
            MODE_INSERT:
            begin
                if (full || (pos_c > cnt_c))
                    err = 1'b1;
                else
                begin
                    op         = ils_pkg::SHIFT_INSERT;
                    target     = pos_i;
                    count_next = count_reg + IW'(1);
                end
            end
            MODE_REMOVE_AT:
            begin
                if (pos_c >= cnt_c)
                    err = 1'b1;
                else
                begin
                    op         = ils_pkg::SHIFT_REMOVE;
                    rd_en      = 1'b1;
                    target     = pos_i;
                    count_next = count_reg - IW'(1);
                end
            end
            MODE_REMOVE_FIRST:
            begin
                if (empty)
                    err = 1'b1;
                else
                begin
                    op         = ils_pkg::SHIFT_REMOVE;
                    rd_en      = 1'b1;
                    count_next = count_reg - IW'(1);
                end
            end
            MODE_REMOVE_LAST:
            begin
                if (empty)
                    err = 1'b1;
                else
                begin
                    op         = ils_pkg::SHIFT_REMOVE;
                    rd_en      = 1'b1;
                    target     = count_reg - IW'(1);
                    count_next = count_reg - IW'(1);
                end
            end
            MODE_READ:
            begin
                if (pos_c >= cnt_c)
                    err = 1'b1;
                else
                begin
                    rd_en  = 1'b1;
                    target = pos_i;
                end
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
        endcase
    end

    // broadcast to the cell row only on an accepted word
    assign ctrl.op     = accept ? op : ils_pkg::SHIFT_HOLD;
    assign ctrl.hit_en = rd_en;

    // row of cells, each wired to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = cell_data[i];
        end
        else
        begin : g_mid_lo
            assign lower = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = cell_data[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_data[i+1];
        end

        ils_cell #(
            .INDEX      (i),
            .IW         (IW),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk    (clk),
            .ctrl   (ctrl),
            .target (target),
            .word   (word),
            .lower  (lower),
            .upper  (upper),
            .data   (cell_data[i]),
            .tap    (cell_tap[i])
        );
    end

    // read word: at most one cell tap is nonzero
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | cell_tap[i];
        end
    end

    assign rd_wide    = (DATA_WIDTH + 32)'(rd_any);
    assign count_wide = (IW + 5)'(count_next);

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (accept)
            count_reg <= count_next;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg   <= rd_wide[31:0];
            entry_count_reg <= count_wide[4:0];
            error_reg       <= err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign entry_count = entry_count_reg;
    assign error       = error_reg;

endmodule

// File: tb/tb.sv
// tb: self-checking testbench for the indexed list store
// keeps its own image of the list, predicts each result word and checks it in order
// depends on the indexed_list_store top level only

module tb;

    localparam int LIST_DEPTH  = 16;
    localparam int DATA_BITS   = 32;
    localparam int STUCK_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;

    // command codes carried in the mode field
    typedef enum logic [2:0] {
        CMD_APPEND,
        CMD_PREPEND,
        CMD_INSERT,
        CMD_REMOVE_AT,
        CMD_REMOVE_FIRST,
        CMD_REMOVE_LAST,
        CMD_READ,
        CMD_CLEAR
    } list_cmd_t;

    // one expected result word
    typedef struct packed {
        logic [31:0] data;
        logic [4:0]  count;
        logic        err;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = 3'd0;
    logic [4:0]  position = 5'd0;
    logic [31:0] value = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic [4:0]  entry_count;
    logic        error;

    // image of the list used for prediction
    logic [31:0]  list_image [LIST_DEPTH];
    int           list_len = 0;
    list_result_t pending_results [$];
    list_result_t oldest_result;
    int           fail_count = 0;
    int           stuck_cycles = 0;
    bit           no_idle = 1'b0;

    indexed_list_store #(
        .CAPACITY   (LIST_DEPTH),
        .DATA_WIDTH (DATA_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .entry_count (entry_count),
        .error       (error)
    );

    always #10 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // open a slot at pos, shifting later entries up
    function automatic void open_slot(int pos, logic [31:0] word);
        for (int i = list_len; i > pos; i--)
            list_image[i] = list_image[i - 1];
        list_image[pos] = word;
        list_len++;
    endfunction

    // take the entry at pos out, shifting later entries down
    function automatic logic [31:0] close_slot(int pos);
        logic [31:0] word;
        word = list_image[pos];
        for (int i = pos; i + 1 < list_len; i++)
            list_image[i] = list_image[i + 1];
        list_len--;
        return word;
    endfunction

    // apply one command to the image and return the result it should give
    function automatic list_result_t predict_list_command(list_cmd_t cmd, logic [4:0] pos,
                                                          logic [31:0] word);
        list_result_t res;
        bit           full;
        int           p;
        res  = '0;
        full = (list_len >= LIST_DEPTH);
        p    = int'(pos);
        case (cmd)
            CMD_APPEND:
                if (full) res.err = 1'b1; else open_slot(list_len, word);
            CMD_PREPEND:
                if (full) res.err = 1'b1; else open_slot(0, word);
            CMD_INSERT:
                if (full || p > list_len) res.err = 1'b1; else open_slot(p, word);
            CMD_REMOVE_AT:
                if (p >= list_len) res.err = 1'b1; else res.data = close_slot(p);
            CMD_REMOVE_FIRST:
                if (list_len == 0) res.err = 1'b1; else res.data = close_slot(0);
            CMD_REMOVE_LAST:
                if (list_len == 0) res.err = 1'b1; else res.data = close_slot(list_len - 1);
            CMD_READ:
                if (p >= list_len) res.err = 1'b1; else res.data = list_image[p];
            default:
                list_len = 0;
        endcase
        res.count = 5'(list_len);
        return res;
    endfunction

    // send one command word and record what it should return
    task automatic send_command(list_cmd_t cmd, logic [4:0] pos, logic [31:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= cmd;
        position <= pos;
        value    <= word;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.insert(pending_results.size(), predict_list_command(cmd, pos, word));
    endtask

    // random data word with the extremes weighted in
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // random position: mostly legal, some on the boundary, some anywhere in the field
    function automatic logic [4:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 5'($urandom_range(0, list_len));
        if (r < 90)
            return 5'(list_len);
        return 5'($urandom_range(0, 31));
    endfunction

    // removals and reads on an empty list, clear on an empty list
    task automatic test_empty_list();
        send_command(CMD_REMOVE_FIRST, 5'd0, 32'd0);
        send_command(CMD_REMOVE_LAST, 5'd0, 32'd0);
        send_command(CMD_REMOVE_AT, 5'd0, 32'd0);
        send_command(CMD_READ, 5'd0, 32'd0);
        send_command(CMD_CLEAR, 5'd0, 32'd0);
    endtask

    // insert, read and remove at the edges of the valid position range
    task automatic test_positions();
        send_command(CMD_PREPEND, 5'd0, 32'hFFFF_FFFF);
        send_command(CMD_APPEND, 5'd0, 32'h0000_0000);
        send_command(CMD_INSERT, 5'd1, 32'hA5A5_A5A5);
        send_command(CMD_INSERT, 5'd3, 32'h5A5A_5A5A);
        send_command(CMD_INSERT, 5'd5, 32'h1234_5678);
        send_command(CMD_INSERT, 5'd31, 32'h8765_4321);
        send_command(CMD_READ, 5'd0, 32'd0);
        send_command(CMD_READ, 5'd3, 32'd0);
        send_command(CMD_READ, 5'd4, 32'd0);
        send_command(CMD_REMOVE_AT, 5'd1, 32'd0);
        send_command(CMD_REMOVE_AT, 5'd31, 32'd0);
        send_command(CMD_REMOVE_FIRST, 5'd0, 32'd0);
        send_command(CMD_REMOVE_LAST, 5'd0, 32'd0);
    endtask

    // fill to capacity, then every insert kind must be refused; then reads, a removal and a clear
    task automatic test_full_list();
        while (list_len < LIST_DEPTH)
            send_command(CMD_APPEND, 5'd0, pick_word());
        send_command(CMD_APPEND, 5'd0, 32'hDEAD_BEEF);
        send_command(CMD_PREPEND, 5'd0, 32'hDEAD_BEEF);
        send_command(CMD_INSERT, 5'd16, 32'hDEAD_BEEF);
        send_command(CMD_READ, 5'd15, 32'd0);
        send_command(CMD_READ, 5'd16, 32'd0);
        send_command(CMD_REMOVE_AT, 5'd15, 32'd0);
        send_command(CMD_CLEAR, 5'd0, 32'd0);
    endtask

    // random command mix; grow_pct sets how often the list is grown
    task automatic test_random_traffic(int n, int grow_pct);
        int        c;
        list_cmd_t cmd;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(0, 99);
            if (c < 3)
                cmd = CMD_CLEAR;
            else if (c < 3 + grow_pct)
                cmd = list_cmd_t'($urandom_range(CMD_APPEND, CMD_INSERT));
            else if (c < 18 + grow_pct)
                cmd = CMD_READ;
            else
                cmd = list_cmd_t'($urandom_range(CMD_REMOVE_AT, CMD_REMOVE_LAST));
            send_command(cmd, pick_position(), pick_word());
        end
    endtask

    // back-to-back commands with no idling on either side
    task automatic test_back_to_back(int n);
        no_idle = 1'b1;
        test_random_traffic(n, 45);
        no_idle = 1'b0;
    endtask

    // output side stall pattern
    initial
    begin
        int n;
        int m;
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            m = no_idle ? 16 : $urandom_range(1, 6);
            repeat (m) @(posedge clk);
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (fail_count < SHOW_LIMIT)
                    $display("unexpected result word: data %h count %0d error %0b",
                             read_data, entry_count, error);
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results[0];
                pending_results.delete(0);
                if (read_data !== oldest_result.data || entry_count !== oldest_result.count
                    || error !== oldest_result.err)
                begin
                    if (fail_count < SHOW_LIMIT)
                        $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                 oldest_result.data, oldest_result.count, oldest_result.err,
                                 read_data, entry_count, error);
                    fail_count++;
                end
            end
        end
    end

    // end the run if nothing moves for too long
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("[indexed_list_store] ERROR");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_positions();
        test_full_list();
        test_random_traffic(400, 65);
        test_random_traffic(400, 20);
        test_random_traffic(700, 42);
        test_back_to_back(400);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[indexed_list_store] OK");
        else
            $display("[indexed_list_store] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ils_pkg.sv
rtl/core/ils_cell.sv
rtl/core/indexed_list_store.sv
tb/tb.sv
